[sv/stft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stft_pkg - shared types and constants of the STFT frame engine
// Request layouts, front/back link structs, sequencer states, twiddle ROM.
// ----------------------------------------------------------------------------
package stft_pkg;

  localparam int FRAME_LEN    = 20;
  localparam int NUM_BINS     = 11;
  localparam int SAMPLE_WIDTH = 16;
  localparam int HOP_RESET    = 5;
  localparam int ACC_W        = 52;
  localparam int RES_W        = 36;

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [4:0]         window_index;
    logic signed [15:0] value;
    logic               first;
  } in_item_t;

  typedef struct packed {
    logic [15:0]              frame_number;
    logic [3:0]               bin_index;
    logic signed [RES_W-1:0]  real_part;
    logic signed [RES_W-1:0]  imag_part;
    logic                     last;
  } out_item_t;

  // Tap read from the back end into the front end's stores
  typedef struct packed {
    logic [4:0] idx;
  } rd_req_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] w;
  } rd_rsp_t;

  typedef struct packed {
    logic [15:0] frame_number;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } bk_state_t;

  // cos(2*pi*p/20) in Q1.15, rounded half away from zero and clamped
  function automatic logic signed [15:0] tw_cos(input logic [4:0] p);
    logic signed [15:0] v;
    case (p)
      5'd0:    v = 16'sd32767;
      5'd1:    v = 16'sd31164;
      5'd2:    v = 16'sd26510;
      5'd3:    v = 16'sd19261;
      5'd4:    v = 16'sd10126;
      5'd5:    v = 16'sd0;
      5'd6:    v = -16'sd10126;
      5'd7:    v = -16'sd19261;
      5'd8:    v = -16'sd26510;
      5'd9:    v = -16'sd31164;
      5'd10:   v = -16'sd32768;
      5'd11:   v = -16'sd31164;
      5'd12:   v = -16'sd26510;
      5'd13:   v = -16'sd19261;
      5'd14:   v = -16'sd10126;
      5'd15:   v = 16'sd0;
      5'd16:   v = 16'sd10126;
      5'd17:   v = 16'sd19261;
      5'd18:   v = 16'sd26510;
      5'd19:   v = 16'sd31164;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // -sin(2*pi*p/20) in Q1.15
  function automatic logic signed [15:0] tw_nsin(input logic [4:0] p);
    logic signed [15:0] v;
    case (p)
      5'd0:    v = 16'sd0;
      5'd1:    v = -16'sd10126;
      5'd2:    v = -16'sd19261;
      5'd3:    v = -16'sd26510;
      5'd4:    v = -16'sd31164;
      5'd5:    v = -16'sd32768;
      5'd6:    v = -16'sd31164;
      5'd7:    v = -16'sd26510;
      5'd8:    v = -16'sd19261;
      5'd9:    v = -16'sd10126;
      5'd10:   v = 16'sd0;
      5'd11:   v = 16'sd10126;
      5'd12:   v = 16'sd19261;
      5'd13:   v = 16'sd26510;
      5'd14:   v = 16'sd31164;
      5'd15:   v = 16'sd32767;
      5'd16:   v = 16'sd31164;
      5'd17:   v = 16'sd26510;
      5'd18:   v = 16'sd19261;
      5'd19:   v = 16'sd10126;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage

[sv/stft_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stft_front - request intake, window store, sample history, frame timing
// Classifies requests, keeps the stores and raises a job per finished frame.
// ----------------------------------------------------------------------------
module stft_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  stft_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  stft_pkg::rd_req_t rd_req,
  output stft_pkg::rd_rsp_t rd_rsp,
  output logic              job_push,
  output stft_pkg::job_t    job_data
);

  logic signed [15:0] hist_r [stft_pkg::FRAME_LEN];
  logic signed [15:0] win_r  [stft_pkg::FRAME_LEN];
  logic [4:0]  seen_r,  seen_nxt;
  logic [7:0]  phase_r, phase_nxt;
  logic [15:0] fc_r,    fc_nxt;
  logic [7:0]  hop_r;
  logic        acc;
  logic        smp;
  logic [4:0]  seen_b, seen_inc;
  logic [7:0]  phase_b;
  logic [15:0] fc_b;

  assign acc = in_valid && !in_stall;
  assign smp = acc && (in_data.kind == stft_pkg::KIND_SAMPLE);

  // tap read for the back end
  assign rd_rsp.x = hist_r[rd_req.idx];
  assign rd_rsp.w = win_r[rd_req.idx];

  // frame timing; a first mark restarts the count
  always_comb begin
    seen_b   = in_data.first ? 5'd0  : seen_r;
    phase_b  = in_data.first ? 8'd0  : phase_r;
    fc_b     = in_data.first ? 16'd0 : fc_r;
    seen_inc = (seen_b < 5'(stft_pkg::FRAME_LEN)) ? seen_b + 5'd1 : seen_b;
    seen_nxt  = seen_r;
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    job_push  = 1'b0;
    job_data.frame_number = fc_b;
    if (smp) begin
      seen_nxt  = seen_inc;
      phase_nxt = phase_b;
      fc_nxt    = fc_b;
      if (seen_inc == 5'(stft_pkg::FRAME_LEN)) begin
        if (phase_b != 8'd0) begin
          phase_nxt = phase_b - 8'd1;
        end else begin
          phase_nxt = hop_r - 8'd1;
          fc_nxt    = fc_b + 16'd1;
          job_push  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      phase_r <= '0;
      fc_r    <= '0;
      hop_r   <= 8'(stft_pkg::HOP_RESET);
    end else begin
      seen_r  <= seen_nxt;
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      if (cfg_valid) begin
        hop_r <= (cfg_data == 8'd0) ? 8'(stft_pkg::HOP_RESET) : cfg_data;
      end
    end
  end

  // window store, cleared at reset; out-of-range loads dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < stft_pkg::FRAME_LEN; i++) win_r[i] <= '0;
    end else if (acc && in_data.kind == stft_pkg::KIND_WINDOW &&
                 in_data.window_index < 5'(stft_pkg::FRAME_LEN)) begin
      win_r[in_data.window_index] <= in_data.value;
    end
  end

  // sample history, newest at the top
  always_ff @(posedge clk) begin
    if (smp) begin
      for (int i = 0; i < stft_pkg::FRAME_LEN - 1; i++) hist_r[i] <= hist_r[i+1];
      hist_r[stft_pkg::FRAME_LEN-1] <= in_data.value;
    end
  end

endmodule

[sv/stft_jobq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stft_jobq - two-entry job queue between front and back end
// Holds frame numbers of finished frames until the back end takes them.
// ----------------------------------------------------------------------------
module stft_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  stft_pkg::job_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output stft_pkg::job_t head
);

  stft_pkg::job_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && cnt_r != 2'd2) ent_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && cnt_r != 2'd2) wp_r <= ~wp_r;
      if (pop && not_empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && cnt_r != 2'd2) - 2'(pop && not_empty);
    end
  end

endmodule

[sv/stft_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stft_back - DFT sequencer and multiply-accumulate pipeline
// Walks bins and taps, accumulates x*w*twiddle, rounds and saturates.
// ----------------------------------------------------------------------------
module stft_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_avail,
  input  stft_pkg::job_t      job,
  output logic                job_pop,
  output logic                busy,
  output stft_pkg::rd_req_t   rd_req,
  input  stft_pkg::rd_rsp_t   rd_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output stft_pkg::out_item_t out_data
);

  localparam int AW = stft_pkg::ACC_W;
  localparam int RW = stft_pkg::RES_W;

  stft_pkg::bk_state_t st_r, st_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [4:0]  p_r, p_nxt;
  logic [3:0]  b_r, b_nxt;
  logic [15:0] fn_r, fn_nxt;
  logic        issue;
  logic [5:0]  p_sum;

  // pipeline registers
  logic               v1_r, v2_r, v3_r;
  logic signed [15:0] x1_r, w1_r, tre1_r, tim1_r, tre2_r, tim2_r;
  logic signed [31:0] xw2_r;
  logic signed [47:0] pre3_r, pim3_r;
  logic signed [AW-1:0] acc_re_r, acc_im_r;
  logic               acc_clr;

  // result formatting
  logic signed [AW:0]   rnd_re, rnd_im;
  logic signed [AW-15:0] sh_re, sh_im;
  logic signed [RW-1:0] sat_re, sat_im;
  logic                 pipe_empty, load_out;
  logic                 out_valid_r;
  stft_pkg::out_item_t  out_data_r;

  assign busy      = (st_r != stft_pkg::BK_IDLE);
  assign rd_req.idx = k_r;
  assign pipe_empty = !v1_r && !v2_r && !v3_r;
  assign p_sum     = {1'b0, p_r} + {2'b00, b_r};

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    k_nxt    = k_r;
    p_nxt    = p_r;
    b_nxt    = b_r;
    fn_nxt   = fn_r;
    issue    = 1'b0;
    job_pop  = 1'b0;
    acc_clr  = 1'b0;
    load_out = 1'b0;
    case (st_r)
      stft_pkg::BK_IDLE: begin
        if (job_avail) begin
          job_pop = 1'b1;
          fn_nxt  = job.frame_number;
          b_nxt   = '0;
          k_nxt   = '0;
          p_nxt   = '0;
          acc_clr = 1'b1;
          st_nxt  = stft_pkg::BK_ISSUE;
        end
      end
      stft_pkg::BK_ISSUE: begin
        issue = 1'b1;
        if (k_r == 5'(stft_pkg::FRAME_LEN - 1)) begin
          st_nxt = stft_pkg::BK_DRAIN;
        end else begin
          k_nxt = k_r + 5'd1;
          p_nxt = (p_sum >= 6'(stft_pkg::FRAME_LEN)) ?
                  5'(p_sum - 6'(stft_pkg::FRAME_LEN)) : p_sum[4:0];
        end
      end
      stft_pkg::BK_DRAIN: begin
        if (pipe_empty && (!out_valid_r || !out_stall)) begin
          load_out = 1'b1;
          acc_clr  = 1'b1;
          k_nxt    = '0;
          p_nxt    = '0;
          if (b_r == 4'(stft_pkg::NUM_BINS - 1)) begin
            st_nxt = stft_pkg::BK_IDLE;
          end else begin
            b_nxt  = b_r + 4'd1;
            st_nxt = stft_pkg::BK_ISSUE;
          end
        end
      end
      default: st_nxt = stft_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= stft_pkg::BK_IDLE;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    k_r  <= k_nxt;
    p_r  <= p_nxt;
    b_r  <= b_nxt;
    fn_r <= fn_nxt;
    // tap fetch and twiddle lookup
    x1_r   <= rd_rsp.x;
    w1_r   <= rd_rsp.w;
    tre1_r <= stft_pkg::tw_cos(p_r);
    tim1_r <= stft_pkg::tw_nsin(p_r);
    // sample times window
    xw2_r  <= x1_r * w1_r;
    tre2_r <= tre1_r;
    tim2_r <= tim1_r;
    // times twiddle
    pre3_r <= xw2_r * tre2_r;
    pim3_r <= xw2_r * tim2_r;
    // accumulate
    if (acc_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v3_r) begin
      acc_re_r <= acc_re_r + AW'(pre3_r);
      acc_im_r <= acc_im_r + AW'(pim3_r);
    end
  end

  // round half up by 2^-15, then saturate to the result width
  always_comb begin
    rnd_re = (AW+1)'(acc_re_r) + (AW+1)'(1 << (stft_pkg::SAMPLE_WIDTH - 2));
    rnd_im = (AW+1)'(acc_im_r) + (AW+1)'(1 << (stft_pkg::SAMPLE_WIDTH - 2));
    sh_re  = rnd_re[AW:stft_pkg::SAMPLE_WIDTH-1];
    sh_im  = rnd_im[AW:stft_pkg::SAMPLE_WIDTH-1];
    if (sh_re > (AW-14)'(36'sh7FFFFFFFF))      sat_re = {1'b0, {(RW-1){1'b1}}};
    else if (sh_re < (AW-14)'(36'sh800000000)) sat_re = {1'b1, {(RW-1){1'b0}}};
    else                                       sat_re = sh_re[RW-1:0];
    if (sh_im > (AW-14)'(36'sh7FFFFFFFF))      sat_im = {1'b0, {(RW-1){1'b1}}};
    else if (sh_im < (AW-14)'(36'sh800000000)) sat_im = {1'b1, {(RW-1){1'b0}}};
    else                                       sat_im = sh_im[RW-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.frame_number <= fn_r;
      out_data_r.bin_index    <= b_r;
      out_data_r.real_part    <= sat_re;
      out_data_r.imag_part    <= sat_im;
      out_data_r.last         <= (b_r == 4'(stft_pkg::NUM_BINS - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/windowed_stft_frame_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_stft_frame_engine - windowed one-sided DFT over a sliding frame
// Takes window loads and samples, emits eleven bins per completed frame.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_stall/in_data carry requests: a window tap load (kind 0)
//    or a Q1.15 sample (kind 1, first marks a new signal).
//  - out_valid/out_stall/out_data carry one bin per result; bin 10 has last.
//  - cfg_valid/cfg_ready/cfg_data write hop_size (zero stores five);
//    cfg_ready is always high, write only while the engine is quiet.
// Timing:
//  - A request that does not finish a frame does not stall intake.
//  - A request that finishes a frame blocks intake while the eleven bins
//    are computed: the job is taken, then each bin issues its twenty taps
//    into the single multiply-accumulate pipeline and drains it.
//    A result that waits on out_stall extends the block.
//  - The first bin is registered once the pipeline has drained its taps.
// Reset: synchronous rst_n clears the window store, frame timing and the
//  output register; hop_size returns to five.
// A stalled result holds in the output register; the sequencer waits for it
//  before loading the next bin.
// ----------------------------------------------------------------------------
module windowed_stft_frame_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stft_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stft_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  stft_pkg::rd_req_t rd_req;
  stft_pkg::rd_rsp_t rd_rsp;
  stft_pkg::job_t    push_job, head_job;
  logic              push, pop, q_ne, bk_busy;

  assign cfg_ready = 1'b1;
  // stores must hold still while a frame is being transformed
  assign in_stall  = q_ne || bk_busy;

  stft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rd_req    (rd_req),
    .rd_rsp    (rd_rsp),
    .job_push  (push),
    .job_data  (push_job)
  );

  stft_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .not_empty (q_ne),
    .head      (head_job)
  );

  stft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (q_ne),
    .job       (head_job),
    .job_pop   (pop),
    .busy      (bk_busy),
    .rd_req    (rd_req),
    .rd_rsp    (rd_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sv/stft_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stft_checker - port-level checks for the STFT frame engine
// Watches result ordering, stall behaviour and reset on the top level.
// ----------------------------------------------------------------------------
module stft_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input stft_pkg::out_item_t out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a stalled request stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled request withdrawn");

  // last marks exactly the top bin
  a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.bin_index == 4'(stft_pkg::NUM_BINS - 1))))
    else $error("last flag and bin index disagree");

  // bins of a frame come in order, same frame number
  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      !out_valid || (out_data.bin_index == $past(out_data.bin_index) + 4'd1 &&
                     out_data.frame_number == $past(out_data.frame_number)))
    else $error("bin sequence broken");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind windowed_stft_frame_engine stft_checker u_stft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
